>>> rtl/crf_pkg.sv
package crf_pkg;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_RAISE = 2'd2,
    REQ_NONE  = 2'd3
  } req_type_e;

  // register offsets
  localparam logic [3:0] OFF_PRA  = 4'd0;
  localparam logic [3:0] OFF_PRB  = 4'd1;
  localparam logic [3:0] OFF_DDRA = 4'd2;
  localparam logic [3:0] OFF_DDRB = 4'd3;
  localparam logic [3:0] OFF_TALO = 4'd4;
  localparam logic [3:0] OFF_TAHI = 4'd5;
  localparam logic [3:0] OFF_TBLO = 4'd6;
  localparam logic [3:0] OFF_TBHI = 4'd7;
  localparam logic [3:0] OFF_ICR  = 4'd13;
  localparam logic [3:0] OFF_CRA  = 4'd14;
  localparam logic [3:0] OFF_CRB  = 4'd15;

  localparam logic [7:0] READ_IDLE = 8'hff;
  localparam int unsigned ICR_SET_BIT = 7;

  typedef struct packed {
    req_type_e  req_type;
    logic [3:0] reg_offset;
    logic [7:0] write_data;
    logic [2:0] flag_bit;
    logic [7:0] port_a_pins;
    logic [7:0] port_b_pins;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       port_b_changed;
    logic       bad_offset;
  } rsp_t;

endpackage

>>> rtl/crf_regs.sv
module crf_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          fire,
  input  crf_pkg::req_t req,
  input  logic          unit_is_second,
  output crf_pkg::rsp_t rsp
);
  import crf_pkg::*;

  logic [7:0]  port_a_latch, port_a_latch_next;
  logic [7:0]  port_b_latch, port_b_latch_next;
  logic [7:0]  dir_a, dir_a_next;
  logic [7:0]  dir_b, dir_b_next;
  logic [15:0] timer_a_reload, timer_a_reload_next;
  logic [15:0] timer_b_reload, timer_b_reload_next;
  logic [6:0]  irq_mask, irq_mask_next;
  logic [7:0]  irq_flags, irq_flags_next;
  logic [7:0]  ctrl_a, ctrl_a_next;
  logic [7:0]  ctrl_b, ctrl_b_next;

  logic       known;
  logic [7:0] rd_val;
  logic       is_wr;
  logic       is_rd;

  always_comb begin
    port_a_latch_next   = port_a_latch;
    port_b_latch_next   = port_b_latch;
    dir_a_next          = dir_a;
    dir_b_next          = dir_b;
    timer_a_reload_next = timer_a_reload;
    timer_b_reload_next = timer_b_reload;
    irq_mask_next       = irq_mask;
    irq_flags_next      = irq_flags;
    ctrl_a_next         = ctrl_a;
    ctrl_b_next         = ctrl_b;
    known               = 1'b1;
    rd_val              = READ_IDLE;
    is_wr               = (req.req_type == REQ_WRITE);
    is_rd               = (req.req_type == REQ_READ);

    unique case (req.reg_offset)
      OFF_PRA: begin
        rd_val = (req.port_a_pins & ~dir_a) | (port_a_latch & dir_a);
        if (is_wr) port_a_latch_next = req.write_data;
      end
      OFF_PRB: begin
        rd_val = (req.port_b_pins & ~dir_b) | (port_b_latch & dir_b);
        if (is_wr) port_b_latch_next = req.write_data;
      end
      OFF_DDRA: begin
        rd_val = dir_a;
        if (is_wr) dir_a_next = req.write_data;
      end
      OFF_DDRB: begin
        rd_val = dir_b;
        if (is_wr) dir_b_next = req.write_data;
      end
      OFF_TALO: begin
        rd_val = timer_a_reload[7:0];
        if (is_wr) timer_a_reload_next = {timer_a_reload[15:8], req.write_data};
      end
      OFF_TAHI: begin
        rd_val = timer_a_reload[15:8];
        if (is_wr) timer_a_reload_next = {req.write_data, timer_a_reload[7:0]};
      end
      OFF_TBLO: begin
        rd_val = timer_b_reload[7:0];
        if (is_wr) timer_b_reload_next = {timer_b_reload[15:8], req.write_data};
      end
      OFF_TBHI: begin
        rd_val = timer_b_reload[15:8];
        if (is_wr) timer_b_reload_next = {req.write_data, timer_b_reload[7:0]};
      end
      OFF_ICR: begin
        rd_val = irq_flags;
        // read clears flags
        if (is_rd) irq_flags_next = '0;
        if (is_wr) begin
          if (req.write_data[ICR_SET_BIT]) begin
            irq_mask_next = irq_mask | req.write_data[6:0];
          end else begin
            irq_mask_next = irq_mask & ~req.write_data[6:0];
          end
        end
      end
      OFF_CRA: begin
        rd_val = ctrl_a;
        if (is_wr) ctrl_a_next = req.write_data;
      end
      OFF_CRB: begin
        rd_val = ctrl_b;
        if (is_wr) ctrl_b_next = req.write_data;
      end
      default: begin
        known = 1'b0;
      end
    endcase

    if (req.req_type == REQ_RAISE) begin
      irq_flags_next = irq_flags | (8'h01 << req.flag_bit);
    end

    rsp.read_data      = is_rd ? rd_val : READ_IDLE;
    rsp.port_b_changed = is_wr && (req.reg_offset == OFF_PRB) && unit_is_second;
    rsp.bad_offset     = (is_wr || is_rd) && !known;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      port_a_latch   <= '0;
      port_b_latch   <= '0;
      dir_a          <= '0;
      dir_b          <= '0;
      timer_a_reload <= '0;
      timer_b_reload <= '0;
      irq_mask       <= '0;
      irq_flags      <= '0;
      ctrl_a         <= '0;
      ctrl_b         <= '0;
    end else if (fire) begin
      port_a_latch   <= port_a_latch_next;
      port_b_latch   <= port_b_latch_next;
      dir_a          <= dir_a_next;
      dir_b          <= dir_b_next;
      timer_a_reload <= timer_a_reload_next;
      timer_b_reload <= timer_b_reload_next;
      irq_mask       <= irq_mask_next;
      irq_flags      <= irq_flags_next;
      ctrl_a         <= ctrl_a_next;
      ctrl_b         <= ctrl_b_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_icr_read_clears: assert property (@(posedge clk) disable iff (rst)
    (fire && is_rd && req.reg_offset == OFF_ICR) |=> (irq_flags == 8'h00))
    else $error("icr read did not clear flags");

  a_idle_holds_state: assert property (@(posedge clk) disable iff (rst)
    !fire |=> ($stable(irq_flags) && $stable(irq_mask) && $stable(port_b_latch)))
    else $error("state changed without a request");

  a_raise_sets_flag: assert property (@(posedge clk) disable iff (rst)
    (fire && req.req_type == REQ_RAISE) |=> (irq_flags[$past(req.flag_bit)] == 1'b1))
    else $error("raised flag not set");
`endif

endmodule

>>> rtl/cia_register_file_unit.sv
// cia register file: an accepted request is loaded into the input register, then
// processed and captured in the result register; throughput one request per cycle
// unless a stalled result blocks it; the input register feeds the result register
// whenever the result register is empty or being taken the same cycle
// reset: synchronous active-high rst clears the port latches, direction masks, timer
// reloads, irq mask and flags, control registers, unit_is_second and both valid bits
module cia_register_file_unit (
  input  logic          clk,
  input  logic          rst,
  // request channel
  input  logic          req_valid,
  output logic          req_stall,
  input  crf_pkg::req_t req,
  // result channel
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output crf_pkg::rsp_t rsp,
  // configuration write channel
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_data
);
  import crf_pkg::*;

  // configuration register
  logic unit_is_second;

  // input register stage
  logic s1_valid, s1_valid_next;
  req_t s1_req;

  // result register stage
  logic rsp_valid_next;
  rsp_t rsp_calc;

  logic accept;
  logic advance;

  // input register moves into the result register when that slot is free or draining
  assign advance   = s1_valid && (!rsp_valid || !rsp_stall);
  // only stall when the input register is full and cannot move on
  assign req_stall = s1_valid && !advance;
  assign accept    = req_valid && !req_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_is_second <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unit_is_second <= cfg_data;
    end
  end

  always_comb begin
    s1_valid_next = s1_valid;
    if (accept) begin
      s1_valid_next = 1'b1;
    end else if (advance) begin
      s1_valid_next = 1'b0;
    end
  end

  always_comb begin
    rsp_valid_next = rsp_valid;
    if (advance) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      s1_valid  <= s1_valid_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req <= req;
    end
    if (advance) begin
      rsp <= rsp_calc;
    end
  end

  // register bank: decode, read mux and state update, committed on advance
  crf_regs u_regs (
    .clk            (clk),
    .rst            (rst),
    .fire           (advance),
    .req            (s1_req),
    .unit_is_second (unit_is_second),
    .rsp            (rsp_calc)
  );

`ifndef NO_ASSERTIONS
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> (s1_valid && rsp_valid && rsp_stall))
    else $error("request stalled without a blocked result");

  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> rsp_valid)
    else $error("result register not filled after advance");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("input register not filled after accept");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.port_b_changed && rsp.bad_offset))
    else $error("change strobe on an unimplemented offset");
`endif

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import crf_pkg::*;

  // unimplemented offsets lie between the timer latches and the icr
  localparam logic [3:0] OFF_HOLE_LO = 4'd8;
  localparam logic [3:0] OFF_HOLE_HI = 4'd12;
  localparam int         CYCLE_LIMIT = 200000;
  localparam int         MAX_REPORTS = 10;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  req_valid = 1'b0;
  logic  req_stall;
  req_t  req = '0;
  logic  rsp_valid;
  logic  rsp_stall = 1'b0;
  rsp_t  rsp;
  logic  cfg_valid = 1'b0;
  logic  cfg_ready;
  logic  cfg_data = 1'b0;

  cia_register_file_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // requests waiting to be driven, and responses predicted but not yet seen
  req_t pending_reqs[$];
  rsp_t rsp_due[$];

  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic req_taken = 1'b0;
  logic cfg_taken = 1'b0;
  int   mismatches = 0;
  int   cycle_cnt = 0;

  // shadow copy of the register file
  logic        second_unit;
  logic [7:0]  lat_a, lat_b, ddr_a, ddr_b;
  logic [15:0] reload_a, reload_b;
  logic [6:0]  int_mask;
  logic [7:0]  int_flags, cra, crb;

  // apply one bus request to the shadow registers and return the response
  function automatic rsp_t bus_access(req_t r);
    rsp_t o;
    logic hole;
    o.read_data      = READ_IDLE;
    o.port_b_changed = 1'b0;
    o.bad_offset     = 1'b0;
    hole = (r.reg_offset > OFF_TBHI) && (r.reg_offset < OFF_ICR);
    case (r.req_type)
      REQ_WRITE: begin
        o.bad_offset     = hole;
        o.port_b_changed = (r.reg_offset == OFF_PRB) && second_unit;
        case (r.reg_offset)
          OFF_PRA:  lat_a = r.write_data;
          OFF_PRB:  lat_b = r.write_data;
          OFF_DDRA: ddr_a = r.write_data;
          OFF_DDRB: ddr_b = r.write_data;
          OFF_TALO: reload_a[7:0] = r.write_data;
          OFF_TAHI: reload_a[15:8] = r.write_data;
          OFF_TBLO: reload_b[7:0] = r.write_data;
          OFF_TBHI: reload_b[15:8] = r.write_data;
          // bit 7 chooses between setting and clearing the named mask bits
          OFF_ICR: begin
            if (r.write_data[ICR_SET_BIT])
              int_mask = int_mask | r.write_data[6:0];
            else
              int_mask = int_mask & ~r.write_data[6:0];
          end
          OFF_CRA:  cra = r.write_data;
          OFF_CRB:  crb = r.write_data;
          default: ;
        endcase
      end
      REQ_READ: begin
        o.bad_offset = hole;
        case (r.reg_offset)
          // direction bit set selects the output latch, clear selects the pin
          OFF_PRA:  o.read_data = (r.port_a_pins & ~ddr_a) | (lat_a & ddr_a);
          OFF_PRB:  o.read_data = (r.port_b_pins & ~ddr_b) | (lat_b & ddr_b);
          OFF_DDRA: o.read_data = ddr_a;
          OFF_DDRB: o.read_data = ddr_b;
          OFF_TALO: o.read_data = reload_a[7:0];
          OFF_TAHI: o.read_data = reload_a[15:8];
          OFF_TBLO: o.read_data = reload_b[7:0];
          OFF_TBHI: o.read_data = reload_b[15:8];
          // flags come back raw and are cleared by the read
          OFF_ICR: begin
            o.read_data = int_flags;
            int_flags   = '0;
          end
          OFF_CRA:  o.read_data = cra;
          OFF_CRB:  o.read_data = crb;
          default: ;
        endcase
      end
      REQ_RAISE: int_flags[r.flag_bit] = 1'b1;
      default: ;
    endcase
    return o;
  endfunction

  // driver: inputs change on the falling edge only
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      rsp_stall <= 1'b0;
    end else begin
      // a request held under stall keeps its payload
      if (!req_valid || req_taken) begin
        if (pending_reqs.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          req       <= pending_reqs.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
      rsp_stall <= ($urandom_range(99, 0) < recv_stall_pct);
    end
  end

  // monitor: sample handshakes on the rising edge, predict and check
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      req_taken   <= 1'b0;
      cfg_taken   <= 1'b0;
      second_unit = 1'b0;
      lat_a       = '0;
      lat_b       = '0;
      ddr_a       = '0;
      ddr_b       = '0;
      reload_a    = '0;
      reload_b    = '0;
      int_mask    = '0;
      int_flags   = '0;
      cra         = '0;
      crb         = '0;
    end else begin
      cycle_cnt++;
      // results always trail acceptance, so check first
      if (rsp_valid && !rsp_stall) begin
        if (rsp_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected response: rd=%h chg=%b bad=%b",
                     rsp.read_data, rsp.port_b_changed, rsp.bad_offset);
        end else begin
          want = rsp_due.pop_front();
          if (rsp.read_data !== want.read_data ||
              rsp.port_b_changed !== want.port_b_changed ||
              rsp.bad_offset !== want.bad_offset) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("mismatch: expected rd=%h chg=%b bad=%b, got rd=%h chg=%b bad=%b",
                       want.read_data, want.port_b_changed, want.bad_offset,
                       rsp.read_data, rsp.port_b_changed, rsp.bad_offset);
          end
        end
      end
      if (req_valid && !req_stall)
        rsp_due.push_back(bus_access(req));
      if (cfg_valid && cfg_ready)
        second_unit = cfg_data;
      req_taken <= req_valid && !req_stall;
      cfg_taken <= cfg_valid && cfg_ready;
      if (cycle_cnt >= CYCLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic add_req(req_type_e kind, logic [3:0] off, logic [7:0] data,
                         logic [2:0] bit_idx, logic [7:0] pa, logic [7:0] pb);
    req_t r;
    r.req_type    = kind;
    r.reg_offset  = off;
    r.write_data  = data;
    r.flag_bit    = bit_idx;
    r.port_a_pins = pa;
    r.port_b_pins = pb;
    pending_reqs.push_back(r);
  endtask

  // mostly reads and writes to real registers, with flag raises so that
  // icr reads return something; a share of holes and no-op requests
  task automatic add_random(int count);
    logic [3:0] known_offs[11];
    req_type_e  kind;
    logic [3:0] off;
    int         pick;
    known_offs = '{OFF_PRA, OFF_PRB, OFF_DDRA, OFF_DDRB, OFF_TALO, OFF_TAHI,
                   OFF_TBLO, OFF_TBHI, OFF_ICR, OFF_CRA, OFF_CRB};
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99, 0);
      if (pick < 5)
        kind = REQ_NONE;
      else if (pick < 40)
        kind = REQ_WRITE;
      else if (pick < 75)
        kind = REQ_READ;
      else
        kind = REQ_RAISE;
      if ($urandom_range(99, 0) < 15)
        off = 4'($urandom_range(OFF_HOLE_HI, OFF_HOLE_LO));
      else
        off = known_offs[$urandom_range(10, 0)];
      add_req(kind, off, 8'($urandom), 3'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  // write the unit select while nothing is in flight
  task automatic write_unit_sel(logic val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    forever begin
      @(negedge clk);
      if (cfg_taken) begin
        cfg_valid <= 1'b0;
        break;
      end
    end
  endtask

  task automatic drain;
    while (pending_reqs.size() != 0 || req_valid || rsp_due.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // directed: every register but the timer-b low byte, both port mixes, flag
    // raise and read-clear, holes and the no-op request type
    write_unit_sel(1'b0);
    add_req(REQ_READ,  OFF_PRA,  8'h00, 3'd0, 8'hff, 8'h00);
    add_req(REQ_READ,  OFF_PRB,  8'hff, 3'd7, 8'h00, 8'h00);
    add_req(REQ_WRITE, OFF_DDRA, 8'hf0, 3'd0, 8'h00, 8'h00);
    add_req(REQ_WRITE, OFF_PRA,  8'ha5, 3'd0, 8'h00, 8'h00);
    add_req(REQ_READ,  OFF_PRA,  8'h00, 3'd0, 8'h0f, 8'hff);
    add_req(REQ_WRITE, OFF_DDRB, 8'hff, 3'd0, 8'h00, 8'h00);
    add_req(REQ_WRITE, OFF_PRB,  8'h00, 3'd0, 8'h00, 8'h00);
    add_req(REQ_READ,  OFF_PRB,  8'h00, 3'd0, 8'h00, 8'hff);
    add_req(REQ_WRITE, OFF_TALO, 8'hff, 3'd0, 8'h00, 8'h00);
    add_req(REQ_WRITE, OFF_TBHI, 8'h80, 3'd0, 8'h00, 8'h00);
    add_req(REQ_READ,  OFF_TALO, 8'h00, 3'd0, 8'h00, 8'h00);
    add_req(REQ_READ,  OFF_TAHI, 8'h00, 3'd0, 8'h00, 8'h00);
    add_req(REQ_READ,  OFF_TBHI, 8'h00, 3'd0, 8'h00, 8'h00);
    add_req(REQ_WRITE, OFF_ICR,  8'hff, 3'd0, 8'h00, 8'h00);
    add_req(REQ_WRITE, OFF_ICR,  8'h7f, 3'd0, 8'h00, 8'h00);
    add_req(REQ_RAISE, OFF_ICR,  8'h00, 3'd7, 8'h00, 8'h00);
    add_req(REQ_RAISE, OFF_PRA,  8'h00, 3'd0, 8'h00, 8'h00);
    add_req(REQ_READ,  OFF_ICR,  8'h00, 3'd0, 8'h00, 8'h00);
    add_req(REQ_READ,  OFF_ICR,  8'h00, 3'd0, 8'h00, 8'h00);
    add_req(REQ_WRITE, OFF_CRA,  8'hff, 3'd0, 8'h00, 8'h00);
    add_req(REQ_WRITE, OFF_CRB,  8'h5a, 3'd0, 8'h00, 8'h00);
    add_req(REQ_READ,  OFF_CRA,  8'h00, 3'd0, 8'h00, 8'h00);
    add_req(REQ_READ,  OFF_CRB,  8'h00, 3'd0, 8'h00, 8'h00);
    add_req(REQ_WRITE, OFF_HOLE_LO, 8'hff, 3'd0, 8'h00, 8'h00);
    add_req(REQ_READ,  OFF_HOLE_HI, 8'h00, 3'd0, 8'h00, 8'h00);
    add_req(REQ_NONE,  OFF_HOLE_LO, 8'hff, 3'd7, 8'hff, 8'hff);
    drain();

    // second unit: port-b writes pulse the change strobe
    write_unit_sel(1'b1);
    send_idle_pct  = 15;
    recv_stall_pct = 80;
    add_random(180);
    drain();

    write_unit_sel(1'b0);
    send_idle_pct  = 80;
    recv_stall_pct = 15;
    add_random(180);
    drain();

    write_unit_sel(1'b1);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    add_random(190);
    drain();

    repeat (4) @(negedge clk);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
